// ----- sv/ssh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssh_pkg
// Hash selection codes, start values and constants of the selectable string
// hash.
// ----------------------------------------------------------------------------
package ssh_pkg;

   typedef enum logic [2:0] {
      HASH_RS   = 3'd0,
      HASH_JS   = 3'd1,
      HASH_PJW  = 3'd2,
      HASH_ELF  = 3'd3,
      HASH_BKDR = 3'd4,
      HASH_SDBM = 3'd5,
      HASH_DJB  = 3'd6,
      HASH_AP   = 3'd7
   } hash_sel_type;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned OUT_W  = 31;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned ADDR_W = 3;

   localparam logic [HASH_W-1:0] RS_START_MULT = 32'd63689;
   localparam logic [HASH_W-1:0] RS_MULT_STEP  = 32'd378551;
   localparam logic [HASH_W-1:0] JS_START      = 32'd1315423911;
   localparam logic [HASH_W-1:0] DJB_START     = 32'd5381;
   localparam logic [HASH_W-1:0] ELF_HIGH      = 32'hF000_0000;

   // register index of hash_select
   localparam logic REG_HASH_SELECT = 1'b0;

   function automatic logic [HASH_W-1:0] start_hash(input hash_sel_type sel);
      logic [HASH_W-1:0] h;
      case (sel)
         HASH_JS:  h = JS_START;
         HASH_DJB: h = DJB_START;
         default:  h = '0;
      endcase
      return h;
   endfunction

endpackage : ssh_pkg
`default_nettype wire

// ----- sv/selectable_string_hash.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// selectable_string_hash
// Byte-serial string hash with a choice of RS, JS, PJW, ELF, BKDR, SDBM, DJB
// or AP, picked by the hash_select register.
// ----------------------------------------------------------------------------
// Key bytes arrive one per transaction on the req_ channel and the block takes
// one every clock cycle unless a closing byte is held back. Each byte is
// captured in an input register and folded into the running hash on the next
// cycle; that fold is a loop whose longest path is the RS update, one 32x32
// multiply plus an add. A zero byte closes the key: its hash, masked to 31
// bits, is loaded into the rsp_ output register and the running state returns
// to the start value of the selected hash. A full output register only holds
// back a closing byte; ordinary key bytes keep flowing. Writing hash_select
// (byte address 0) also reloads the start state, dropping any partial key.
// ----------------------------------------------------------------------------
module selectable_string_hash (
   input  wire                           clock,
   input  wire                           reset,
   // key byte channel
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [ssh_pkg::BYTE_W-1:0]    req_key_byte,
   // hash result channel
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [ssh_pkg::OUT_W-1:0]     rsp_hash_value,
   // register port
   input  wire                           csr_psel,
   input  wire                           csr_penable,
   input  wire                           csr_pwrite,
   input  wire  [ssh_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire  [ssh_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [ssh_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import ssh_pkg::*;

   hash_sel_type        sel_ff;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [HASH_W-1:0]   mult_ff, mult_in;
   logic                parity_ff, parity_in;
   logic [BYTE_W-1:0]   byte_ff;
   logic                in_valid_ff;
   logic                out_valid_ff;
   logic [OUT_W-1:0]    out_hash_ff;

   logic                cfg_write;
   logic                step;
   logic                key_end;
   logic [HASH_W-1:0]   c;
   logic [HASH_W-1:0]   t;
   logic [HASH_W-1:0]   top;

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_HASH_SELECT);
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(DATA_W-3){1'b0}}, sel_ff};

   assign key_end   = (byte_ff == '0);
   // a closing byte waits for room in the output register
   assign step      = in_valid_ff && (!key_end || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   assign rsp_valid      = out_valid_ff;
   assign rsp_hash_value = out_hash_ff;

   assign c = {{(HASH_W-BYTE_W){1'b0}}, byte_ff};

   always_comb begin
      hash_in   = hash_ff;
      mult_in   = mult_ff;
      parity_in = parity_ff;
      t         = '0;
      top       = '0;
      case (sel_ff)
         HASH_RS: begin
            hash_in = (hash_ff * mult_ff) + c;
            mult_in = mult_ff * RS_MULT_STEP;
         end
         HASH_JS: begin
            hash_in = hash_ff ^ ((hash_ff << 5) + c + (hash_ff >> 2));
         end
         HASH_PJW, HASH_ELF: begin
            t       = (hash_ff << 4) + c;
            top     = t & ELF_HIGH;
            hash_in = (t ^ (top >> 24)) & ~top;
         end
         HASH_BKDR: begin
            // seed 131 = 128 + 2 + 1
            hash_in = (hash_ff << 7) + (hash_ff << 1) + hash_ff + c;
         end
         HASH_SDBM: begin
            hash_in = c + (hash_ff << 6) + (hash_ff << 16) - hash_ff;
         end
         HASH_DJB: begin
            hash_in = hash_ff + (hash_ff << 5) + c;
         end
         HASH_AP: begin
            if (!parity_ff) begin
               hash_in = hash_ff ^ ((hash_ff << 7) ^ c ^ (hash_ff >> 3));
            end else begin
               hash_in = hash_ff ^ ~((hash_ff << 11) ^ c ^ (hash_ff >> 5));
            end
            parity_in = !parity_ff;
         end
         default: begin
            hash_in = hash_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= HASH_RS;
         hash_ff      <= start_hash(HASH_RS);
         mult_ff      <= RS_START_MULT;
         parity_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            sel_ff    <= hash_sel_type'(csr_pwdata[2:0]);
            hash_ff   <= start_hash(hash_sel_type'(csr_pwdata[2:0]));
            mult_ff   <= RS_START_MULT;
            parity_ff <= 1'b0;
         end else if (step) begin
            if (key_end) begin
               hash_ff   <= start_hash(sel_ff);
               mult_ff   <= RS_START_MULT;
               parity_ff <= 1'b0;
            end else begin
               hash_ff   <= hash_in;
               mult_ff   <= mult_in;
               parity_ff <= parity_in;
            end
         end

         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end

         if (step && key_end) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_key_byte;
      end
      if (step && key_end) begin
         out_hash_ff <= hash_ff[OUT_W-1:0];
      end
   end

endmodule : selectable_string_hash
`default_nettype wire

// ----- tb/selectable_string_hash_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selectable_string_hash_tb
// Feeds keys byte by byte under each of the eight hash selections. A local
// model of every hash predicts the 31-bit value of each key, and the checker
// compares each result with the oldest prediction. hash_select is written
// through the register port between phases and read back after each write.
// ----------------------------------------------------------------------------
module selectable_string_hash_tb;
   import ssh_pkg::*;

   localparam logic [ADDR_W-1:0] SEL_ADDR      = 3'd0;
   localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
   localparam logic [HASH_W-1:0] BKDR_SEED     = 32'd131;
   localparam int RANDOM_ITEMS = 480;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_LIMIT = 2000;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_key_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [OUT_W-1:0]     rsp_hash_value;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_W-1:0]    csr_paddr;
   logic [DATA_W-1:0]    csr_pwdata;
   logic [DATA_W-1:0]    csr_prdata;
   logic                 csr_pready;

   // model of the block
   hash_sel_type         cur_sel;
   logic [HASH_W-1:0]    run_hash;
   logic [HASH_W-1:0]    rs_mult;
   logic                 ap_odd;
   logic [OUT_W-1:0]     pending_hashes[$];

   int                   mismatches;
   int                   burst_left;
   int                   idle_cycles;
   logic [OUT_W-1:0]     want_hash;

   selectable_string_hash DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_byte   (req_key_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void reload_start();
      case (cur_sel)
         HASH_JS:  run_hash = JS_START;
         HASH_DJB: run_hash = DJB_START;
         default:  run_hash = '0;
      endcase
      rs_mult = RS_START_MULT;
      ap_odd = 1'b0;
   endfunction

   // fold one key byte into the running hash, or close the key on a zero byte
   function automatic void hash_key_byte(input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] c;
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] top;
      c = {24'b0, b};
      h = run_hash;
      if (b == 8'h00) begin
         pending_hashes.push_back(h[OUT_W-1:0]);
         reload_start();
         return;
      end
      case (cur_sel)
         HASH_RS: begin
            h = h * rs_mult + c;
            rs_mult = rs_mult * RS_MULT_STEP;
         end
         HASH_JS:   h = h ^ ((h << 5) + c + (h >> 2));
         HASH_PJW, HASH_ELF: begin
            h = (h << 4) + c;
            top = h & ELF_HIGH;
            if (top != '0) begin
               h = h ^ (top >> 24);
               h = h & ~top;
            end
         end
         HASH_BKDR: h = h * BKDR_SEED + c;
         HASH_SDBM: h = c + (h << 6) + (h << 16) - h;
         HASH_DJB:  h = h + (h << 5) + c;
         default: begin
            if (!ap_odd)
               h = h ^ ((h << 7) ^ c ^ (h >> 3));
            else
               h = h ^ ~((h << 11) ^ c ^ (h >> 5));
            ap_odd = ~ap_odd;
         end
      endcase
      run_hash = h;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ERROR: %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_key_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      hash_key_byte(b);
      @(negedge clock);
   endtask

   task automatic send_key(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(1, 255)));
      send_byte(8'h00);
   endtask

   // register write while the block is idle, then read back a mapped register
   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(negedge clock);
      // last key byte may still be folding
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == SEL_ADDR) begin
         cur_sel = hash_sel_type'(data[2:0]);
         reload_start();
      end
      @(negedge clock);
      if (addr == SEL_ADDR) begin
         csr_pwrite <= 1'b0;
         csr_penable <= 1'b0;
         @(negedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         if (csr_prdata !== {29'b0, cur_sel})
            report_mismatch("hash_select readback", csr_prdata, {29'b0, cur_sel});
         @(negedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic test_empty_keys();
      for (int s = 0; s < 8; s++) begin
         csr_write(SEL_ADDR, DATA_W'(s));
         send_byte(8'h00);
      end
   endtask

   task automatic test_byte_extremes();
      csr_write(SEL_ADDR, DATA_W'(HASH_AP));
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h00);
   endtask

   // a write to hash_select drops the partial key; upper data bits are ignored
   task automatic test_partial_key_dropped();
      csr_write(SEL_ADDR, DATA_W'(HASH_DJB));
      send_byte(8'h61);
      send_byte(8'h62);
      csr_write(SEL_ADDR, 32'hFFFF_FFF8 | DATA_W'(HASH_DJB));
      send_byte(8'h63);
      send_byte(8'h00);
   endtask

   // a write to an unmapped address must leave the partial key alone
   task automatic test_unmapped_register();
      send_byte(8'h78);
      csr_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
      send_byte(8'h79);
      send_byte(8'h00);
   endtask

   task automatic test_random_keys();
      int sent;
      int phase;
      int len;
      hash_sel_type sel;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         sel = (phase < 8) ? hash_sel_type'(phase) : hash_sel_type'($urandom_range(0, 7));
         csr_write(SEL_ADDR, ($urandom & ~32'h7) | DATA_W'(sel));
         repeat ($urandom_range(4, 10)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(0, 10);
            send_key(len);
            sent += len + 1;
         end
         // sometimes leave a partial key for the next write to drop
         if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) send_byte(8'($urandom_range(1, 255)));
            sent += len;
         end
         phase++;
      end
   endtask

   // receiver stall patterns
   initial begin
      rx_mode_type mode;
      int span;
      int tick;
      rsp_ready = 1'b0;
      tick = 0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 200);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
               default:   rsp_ready <= ((tick % 5) < 2);
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hashes.size() == 0) begin
            report_mismatch("unexpected hash transaction", {1'b0, rsp_hash_value}, '0);
         end else begin
            want_hash = pending_hashes.pop_front();
            if (rsp_hash_value !== want_hash)
               report_mismatch("hash_value", {1'b0, rsp_hash_value}, {1'b0, want_hash});
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ERROR: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
         $display("selectable_string_hash: mismatch");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_key_byte = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatches = 0;
      burst_left = 0;
      idle_cycles = 0;
      cur_sel = HASH_RS;
      reload_start();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_keys();
      test_byte_extremes();
      test_partial_key_dropped();
      test_unmapped_register();
      test_random_keys();

      req_valid <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("selectable_string_hash: match");
      end else begin
         $display("selectable_string_hash: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/ssh_pkg.sv
sv/selectable_string_hash.sv
tb/selectable_string_hash_tb.sv
